// ===== rtl/lce_pkg.sv =====
// Shared types and constants for the cellular automaton engine.
// No dependencies; every other file in rtl/ except lce_row_cell.sv refers to it by scoped names.
`timescale 1ns / 1ps

package lce_pkg;

   localparam int KIND_W     = 2;
   localparam int COL_W      = 6;
   localparam int ROW_W      = 6;
   localparam int CFG_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

   // Glider seed, columns 0..3 of rows 1..3
   localparam logic [3:0] GLIDER_ROW1 = 4'b1000;
   localparam logic [3:0] GLIDER_ROW2 = 4'b1010;
   localparam logic [3:0] GLIDER_ROW3 = 4'b1100;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE   = 2'd0,
      KIND_READ    = 2'd1,
      KIND_ADVANCE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

   // Which of the three rows around the head of the chain lie inside the region
   typedef struct packed {
      logic prev_live;
      logic row_live;
      logic next_live;
   } sweep_ctrl_type;

endpackage

// ===== rtl/life_cellular_automaton_engine.sv =====
// Cellular automaton engine (B3/S23) on a MAX_HEIGHT by MAX_WIDTH grid.
// Request channel req_*: tuser carries the kind (write, read, advance),
// tdata the column, row and value. Response channel rsp_*: one response per
// request, tdata carries the cell state read and a done flag.
// The grid sits in a ring of MAX_HEIGHT row cells. Every request makes the
// ring revolve once: each row passes the head of the chain, where a write or
// read is applied or the row's next generation is computed from the rows on
// either side. The next request is taken only once the revolution has ended
// and the block is idle again.
// A response left waiting does not block acceptance of the next request; if
// it is still waiting when that request ends, the block holds after the
// revolution until the receiver takes it.
// csr_*: grid_width (index 0), grid_height (index 1); the user must write them
// only while idle (unenforced by the block); values saturate to 1..MAX_WIDTH / 1..MAX_HEIGHT.
// Synchronous reset sets both sizes to 64, clears the grid and seeds a glider
// at the top left in the same cycle; no clearing pass follows.
`timescale 1ns / 1ps

module life_cellular_automaton_engine #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [5:0] column, [11:6] row, [12] cell_value, [15:13] zero
   input  logic [lce_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] kind
   input  logic [lce_pkg::KIND_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] cell_state, [1] done_res, [7:2] zero
   output logic [lce_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [lce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lce_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int XW0 = $clog2(MAX_WIDTH + 1);
   localparam int YW0 = $clog2(MAX_HEIGHT + 1);
   localparam int XW  = (XW0 > lce_pkg::CFG_W) ? XW0 : lce_pkg::CFG_W;
   localparam int YW  = (YW0 > lce_pkg::CFG_W) ? YW0 : lce_pkg::CFG_W;

   lce_pkg::state_type             state_ff, state_in;
   lce_pkg::kind_type              kind_ff, kind_in;
   logic [lce_pkg::COL_W-1:0]      col_ff, col_in;
   logic [lce_pkg::ROW_W-1:0]      sel_row_ff, sel_row_in;
   logic                           val_ff, val_in;
   logic [RW-1:0]                  count_ff, count_in;
   logic [MAX_WIDTH-1:0]           prev_ff, prev_in;
   logic                           hit_ff, hit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_state_ff, rsp_state_in;
   logic [lce_pkg::CFG_W-1:0]      width_ff, width_in;
   logic [lce_pkg::CFG_W-1:0]      height_ff, height_in;

   logic [MAX_WIDTH-1:0]           rows [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0]           new_row;
   logic [MAX_WIDTH-1:0]           life_row;
   logic [MAX_WIDTH-1:0]           edit_row;
   logic [MAX_WIDTH-1:0]           col_en;
   logic [MAX_WIDTH-1:0]           col_hit;
   logic [XW-1:0]                  eff_w;
   logic [YW-1:0]                  eff_h;
   logic                           in_region;
   logic                           row_match;
   logic                           read_bit;
   logic                           shift_en;
   logic                           slot_free;
   lce_pkg::sweep_ctrl_type        ctrl;

   // Configuration
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lce_pkg::CSR_GRID_WIDTH:  width_in  = csr_wdata;
            lce_pkg::CSR_GRID_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = XW'(1);
      end else if (XW'(width_ff) > XW'(MAX_WIDTH)) begin
         eff_w = XW'(MAX_WIDTH);
      end else begin
         eff_w = XW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = YW'(1);
      end else if (YW'(height_ff) > YW'(MAX_HEIGHT)) begin
         eff_h = YW'(MAX_HEIGHT);
      end else begin
         eff_h = YW'(height_ff);
      end
   end

   // Row ring
   genvar g;
   generate
      for (g = 0; g < MAX_HEIGHT; g++) begin : g_cell
         localparam logic [MAX_WIDTH-1:0] ROW_RST =
            (g == 1) ? MAX_WIDTH'(lce_pkg::GLIDER_ROW1) :
            (g == 2) ? MAX_WIDTH'(lce_pkg::GLIDER_ROW2) :
            (g == 3) ? MAX_WIDTH'(lce_pkg::GLIDER_ROW3) : '0;
         logic [MAX_WIDTH-1:0] din;
         if (g == MAX_HEIGHT - 1) begin : g_tail
            assign din = new_row;
         end else begin : g_link
            assign din = rows[g+1];
         end
         lce_row_cell #(
            .WIDTH     (MAX_WIDTH),
            .RESET_ROW (ROW_RST)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .row_din  (din),
            .row_dout (rows[g])
         );
      end
   endgenerate

   // Head of the chain: row count_ff sits in rows[0]
   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         col_en[i]  = XW'(i) < eff_w;
         col_hit[i] = XW'(i) == XW'(col_ff);
      end
      in_region = (XW'(col_ff) < eff_w) && (YW'(sel_row_ff) < eff_h);
      row_match = YW'(count_ff) == YW'(sel_row_ff);
      read_bit  = |(rows[0] & col_hit);

      ctrl.prev_live = count_ff != '0;
      ctrl.row_live  = YW'(count_ff) < eff_h;
      ctrl.next_live = (YW'(count_ff) + YW'(1)) < eff_h;

      edit_row = rows[0];
      if (kind_ff == lce_pkg::KIND_WRITE && row_match && in_region) begin
         edit_row = (rows[0] & ~col_hit) | (col_hit & {MAX_WIDTH{val_ff}});
      end
      new_row = (kind_ff == lce_pkg::KIND_ADVANCE) ? life_row : edit_row;
   end

   lce_rule_unit #(
      .WIDTH (MAX_WIDTH)
   ) u_rule (
      .prev_row (prev_ff),
      .cur_row  (rows[0]),
      .next_row (rows[1]),
      .col_en   (col_en),
      .ctrl     (ctrl),
      .life_row (life_row)
   );

   // Control
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      col_in       = col_ff;
      sel_row_in   = sel_row_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      hit_in       = hit_ff;
      rsp_state_in = rsp_state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      shift_en     = 1'b0;
      case (state_ff)
         lce_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in    = lce_pkg::kind_type'(req_tuser);
               col_in     = req_tdata[lce_pkg::COL_W-1:0];
               sel_row_in = req_tdata[lce_pkg::COL_W +: lce_pkg::ROW_W];
               val_in     = req_tdata[lce_pkg::COL_W + lce_pkg::ROW_W];
               count_in   = '0;
               hit_in     = 1'b0;
               state_in   = lce_pkg::ST_SWEEP;
            end
         end
         lce_pkg::ST_SWEEP: begin
            shift_en = 1'b1;
            prev_in  = rows[0];
            count_in = count_ff + RW'(1);
            if (kind_ff == lce_pkg::KIND_READ && row_match && in_region && read_bit) begin
               hit_in = 1'b1;
            end
            if (count_ff == RW'(MAX_HEIGHT - 1)) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_state_in = hit_in;
                  state_in     = lce_pkg::ST_IDLE;
               end else begin
                  state_in = lce_pkg::ST_FLUSH;
               end
            end
         end
         lce_pkg::ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = hit_ff;
               state_in     = lce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lce_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lce_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= lce_pkg::GRID_SIZE_RESET;
         height_ff    <= lce_pkg::GRID_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      col_ff       <= col_in;
      sel_row_ff   <= sel_row_in;
      val_ff       <= val_in;
      count_ff     <= count_in;
      prev_ff      <= prev_in;
      hit_ff       <= hit_in;
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lce_pkg::RSP_DATA_W - 2){1'b0}}, 1'b1, rsp_state_ff};

endmodule

// ===== rtl/lce_row_cell.sv =====
// One cell of the row chain: holds one grid row and hands it to its neighbour.
// Uses no package items.
`timescale 1ns / 1ps

module lce_row_cell #(
   parameter int                 WIDTH     = 64,
   parameter logic [WIDTH-1:0]   RESET_ROW = '0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] row_din,
   output logic [WIDTH-1:0] row_dout
);

   logic [WIDTH-1:0] row_ff;
   logic [WIDTH-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (shift_en) begin
         row_in = row_din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= RESET_ROW;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_dout = row_ff;

endmodule

// ===== rtl/lce_rule_unit.sv =====
// Row-wide B3/S23 update: next value of one row from itself and the rows above and below.
// Depends on lce_pkg for the sweep control struct.
`timescale 1ns / 1ps

module lce_rule_unit #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]        prev_row,
   input  logic [WIDTH-1:0]        cur_row,
   input  logic [WIDTH-1:0]        next_row,
   input  logic [WIDTH-1:0]        col_en,
   input  lce_pkg::sweep_ctrl_type ctrl,
   output logic [WIDTH-1:0]        life_row
);

   logic [WIDTH+1:0] p_pad;
   logic [WIDTH+1:0] c_pad;
   logic [WIDTH+1:0] n_pad;

   // Dead border: mask columns and rows outside the region, pad both ends
   always_comb begin
      p_pad = {1'b0, prev_row & col_en & {WIDTH{ctrl.prev_live}}, 1'b0};
      c_pad = {1'b0, cur_row & col_en, 1'b0};
      n_pad = {1'b0, next_row & col_en & {WIDTH{ctrl.next_live}}, 1'b0};
   end

   always_comb begin
      logic [3:0] n;
      for (int i = 0; i < WIDTH; i++) begin
         n = 4'(p_pad[i]) + 4'(p_pad[i+1]) + 4'(p_pad[i+2])
           + 4'(c_pad[i]) + 4'(c_pad[i+2])
           + 4'(n_pad[i]) + 4'(n_pad[i+1]) + 4'(n_pad[i+2]);
         life_row[i] = col_en[i] & ctrl.row_live
                     & ((n == 4'd3) | (c_pad[i+1] & (n == 4'd2)));
      end
   end

endmodule

// ===== rtl/lce_checker.sv =====
// Port-level checks for the cellular automaton engine, bound to the top level.
// Depends on the port list of life_cellular_automaton_engine and lce_pkg widths.
`timescale 1ns / 1ps

module lce_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lce_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every response carries the done flag
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1])
      else $error("response without done flag");

   // An accepted request keeps the block busy for its revolution
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during a revolution");

   // Reset leaves the block idle with no response pending
   a_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind life_cellular_automaton_engine lce_checker u_lce_checker (.*);

// ===== bench/life_cellular_automaton_engine_test.sv =====
// Self-checking bench for the B3/S23 cellular automaton engine: drives cell writes, reads and
// generation steps through several grid sizes and checks every response against its own grid.
// Depends on rtl/lce_pkg.sv and rtl/life_cellular_automaton_engine.sv.
`timescale 1ns / 1ps

module life_cellular_automaton_engine_test;
   import lce_pkg::*;

   localparam int GRID_MAX    = 64;
   // Slowest item: a full rotation, a receiver hold of HOLD_CYCLES and a long gap on top
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      bit cell_state;
      bit done_res;
   } cell_response_type;

   class life_grid_scoreboard;
      bit [GRID_MAX-1:0] cells[GRID_MAX];
      bit [CFG_W-1:0]    width_reg;
      bit [CFG_W-1:0]    height_reg;
      cell_response_type expected_responses[$];
      int                errors;

      function new();
         for (int r = 0; r < GRID_MAX; r++) cells[r] = '0;
         // glider at the top left, indexed [row][column]
         cells[2][1] = 1'b1;
         cells[1][3] = 1'b1;
         cells[2][3] = 1'b1;
         cells[3][3] = 1'b1;
         cells[3][2] = 1'b1;
         width_reg  = GRID_SIZE_RESET;
         height_reg = GRID_SIZE_RESET;
         errors     = 0;
      endfunction

      function int saturate(bit [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > GRID_MAX) return GRID_MAX;
         return int'(v);
      endfunction

      function int region_width();
         return saturate(width_reg);
      endfunction

      function int region_height();
         return saturate(height_reg);
      endfunction

      function void set_register(csr_index_type idx, bit [CFG_W-1:0] value);
         if (idx == CSR_GRID_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      function void advance_generation();
         bit [GRID_MAX-1:0] nxt[GRID_MAX];
         int w, h, n, rr, cc;
         w = region_width();
         h = region_height();
         for (int r = 0; r < GRID_MAX; r++) begin
            nxt[r] = '0;
            for (int c = 0; c < GRID_MAX; c++) begin
               if (r < h && c < w) begin
                  n = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h && cc < w)
                           n += cells[rr][cc];
                     end
                  end
                  nxt[r][c] = cells[r][c] ? (n == 2 || n == 3) : (n == 3);
               end
            end
         end
         cells = nxt;
      endfunction

      function void note_request(kind_type kind, bit [COL_W-1:0] col, bit [ROW_W-1:0] row,
                                 bit value);
         cell_response_type rsp;
         bit inside_region;
         inside_region  = (col < region_width()) && (row < region_height());
         rsp.cell_state = 1'b0;
         rsp.done_res   = 1'b1;
         case (kind)
            KIND_WRITE: begin
               if (inside_region) cells[row][col] = value;
            end
            KIND_READ: begin
               if (inside_region) rsp.cell_state = cells[row][col];
            end
            KIND_ADVANCE: begin
               advance_generation();
            end
            default: ;
         endcase
         expected_responses.push_back(rsp);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         cell_response_type rsp;
         if (expected_responses.size() == 0) begin
            $display("%0t: response 0x%0h arrived with nothing expected", $time, data);
            errors++;
            return;
         end
         rsp = expected_responses.pop_front();
         if (data[0] !== rsp.cell_state) begin
            $display("%0t: cell_state expected %0b, got %0b", $time, rsp.cell_state, data[0]);
            errors++;
         end
         if (data[1] !== rsp.done_res) begin
            $display("%0t: done_res expected %0b, got %0b", $time, rsp.done_res, data[1]);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   life_grid_scoreboard sb;
   bit no_gaps;
   bit hold_receiver;

   life_cellular_automaton_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Leave tvalid high on return so that back-to-back transactions never drop it
   task send_request(kind_type kind, int col, int row, bit value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, value, row[ROW_W-1:0], col[COL_W-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, col[COL_W-1:0], row[ROW_W-1:0], value);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task set_grid_size(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.set_register(CSR_GRID_WIDTH, w);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.set_register(CSR_GRID_HEIGHT, h);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task fill_region();
      for (int r = 0; r < sb.region_height(); r++)
         for (int c = 0; c < sb.region_width(); c++)
            send_request(KIND_WRITE, c, r, $urandom_range(0, 99) < 40);
   endtask

   // Mostly work inside an 8x8 window of the region so that patterns interact
   task random_traffic(int count);
      int w, h, ox, oy, k, col, row;
      kind_type kind;
      w  = sb.region_width();
      h  = sb.region_height();
      ox = (w > 8) ? $urandom_range(0, w - 8) : 0;
      oy = (h > 8) ? $urandom_range(0, h - 8) : 0;
      repeat (count) begin
         k = $urandom_range(0, 99);
         kind = (k < 45) ? KIND_WRITE : (k < 75) ? KIND_READ :
                (k < 93) ? KIND_ADVANCE : KIND_NONE;
         if ($urandom_range(0, 4) == 0) begin
            col = $urandom_range(0, GRID_MAX - 1);
            row = $urandom_range(0, GRID_MAX - 1);
         end else begin
            col = ox + $urandom_range(0, ((w < 8) ? w : 8) - 1);
            row = oy + $urandom_range(0, ((h < 8) ? h : 8) - 1);
         end
         send_request(kind, col, row, $urandom_range(0, 99) < 45);
      end
   endtask

   initial begin : receiver
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            stall = HOLD_CYCLES;
         end else if (stall == 0) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      no_gaps       = 1'b0;
      hold_receiver = 1'b0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_WRITE;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_GRID_WIDTH;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Seeded glider, corners of the full grid, the unused kind, border deaths
      send_request(KIND_READ, 1, 2, 1'b0);
      send_request(KIND_READ, 3, 1, 1'b0);
      send_request(KIND_READ, 3, 2, 1'b0);
      send_request(KIND_READ, 3, 3, 1'b0);
      send_request(KIND_READ, 2, 3, 1'b0);
      send_request(KIND_READ, 0, 0, 1'b0);
      send_request(KIND_READ, 2, 2, 1'b0);
      send_request(KIND_ADVANCE, 0, 0, 1'b0);
      send_request(KIND_READ, 2, 2, 1'b0);
      send_request(KIND_WRITE, 63, 63, 1'b1);
      send_request(KIND_READ, 63, 63, 1'b0);
      send_request(KIND_WRITE, 0, 63, 1'b1);
      send_request(KIND_WRITE, 63, 0, 1'b1);
      send_request(KIND_READ, 0, 63, 1'b0);
      send_request(KIND_WRITE, 63, 63, 1'b0);
      send_request(KIND_READ, 63, 63, 1'b0);
      send_request(KIND_NONE, 63, 63, 1'b1);
      send_request(KIND_READ, 63, 0, 1'b0);
      send_request(KIND_ADVANCE, 63, 63, 1'b1);
      send_request(KIND_READ, 63, 0, 1'b0);
      send_request(KIND_ADVANCE, 0, 0, 1'b0);
      send_request(KIND_ADVANCE, 0, 0, 1'b0);
      send_request(KIND_READ, 2, 2, 1'b0);

      // Full grid with a long receiver hold: the block must back-pressure its input
      hold_receiver = 1'b1;
      random_traffic(100);
      drain();

      set_grid_size(7'd1, 7'd1);
      random_traffic(40);
      drain();

      // Out-of-range sizes saturate: zero acts as one, anything above 64 as 64
      set_grid_size(7'd0, 7'd127);
      random_traffic(50);
      drain();
      set_grid_size(7'd127, 7'd0);
      random_traffic(50);
      drain();

      set_grid_size(7'd8, 7'd8);
      fill_region();
      random_traffic(80);
      drain();

      no_gaps = 1'b1;
      set_grid_size(7'd5, 7'd7);
      fill_region();
      random_traffic(80);
      drain();
      no_gaps = 1'b0;

      set_grid_size(7'd3, 7'd64);
      random_traffic(60);
      drain();

      set_grid_size(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)));
      fill_region();
      random_traffic(60);
      drain();

      // Shrink and regrow: hidden cells reappear without an advance; an advance in the 8x8 grid clears them
      set_grid_size(7'd64, 7'd64);
      send_request(KIND_WRITE, 40, 40, 1'b1);
      send_request(KIND_WRITE, 41, 40, 1'b1);
      drain();
      set_grid_size(7'd8, 7'd8);
      send_request(KIND_READ, 40, 40, 1'b0);
      send_request(KIND_WRITE, 41, 40, 1'b0);
      drain();
      set_grid_size(7'd64, 7'd64);
      send_request(KIND_READ, 40, 40, 1'b0);
      send_request(KIND_READ, 41, 40, 1'b0);
      drain();
      set_grid_size(7'd8, 7'd8);
      send_request(KIND_ADVANCE, 0, 0, 1'b0);
      drain();
      set_grid_size(7'd64, 7'd64);
      send_request(KIND_READ, 40, 40, 1'b0);
      random_traffic(100);
      drain();

      repeat (70) @(posedge clock);
      if (sb.outstanding() != 0)
         $display("%0t: %0d responses never arrived", $time, sb.outstanding());
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
